// ===== hdl/sv39m_pkg.sv =====
`default_nettype none
package sv39m_pkg;

  localparam int POOL_PAGES = 16;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int IDX_W = 9;
  localparam int PAGE_W = $clog2(POOL_PAGES);
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH = POOL_PAGES * ENTRIES_PER_PAGE;
  localparam int PPN_W = 44;
  localparam int VPN_W = 27;
  localparam int ENTRY_W = 64;
  localparam int CNT_W = 9;  // holds POOL_PAGES at its largest

  localparam logic [9:0] FLAG_V = 10'h001;
  localparam logic [9:0] FLAGS_LEAF = 10'h00f;

  typedef enum logic [1:0] {
    ST_MAPPED    = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_ROOT_PAGE  = 2'd1,
    CFG_FIRST_FREE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } walk_state_e;

  typedef struct packed {
    logic [VPN_W-1:0] virt_page;
    logic [PPN_W-1:0] phys_page;
  } map_req_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] pages_allocated;
    logic       was_valid;
    logic [4:0] free_pages_left;
  } map_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/sv39_page_table_mapper.sv =====
// Sv39 page-table mapper: installs one 4 KiB leaf mapping per request in a
// three-level page table kept in a local pool of table pages.
// Input channel (in_valid_i/in_ready_o, in_data_i): virtual and physical
// page number. Output channel (out_valid_o/out_ready_i, out_data_o): one
// status word per request (status, new table pages taken, remap flag,
// free pool pages left).
// A full walk runs one read and one evaluate state per level, then finish;
// a walk that stops early goes straight to finish. One request is in flight
// at a time, as the three dependent reads of a full walk share the
// single-port table memory; the next request is taken in the cycle after
// finish.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, taken in any cycle; write
// only while no request is in flight.
// Reset: the table memory (POOL_PAGES*512 entries, 8192 at 16 pages) is
// cleared by a sweep of one entry per cycle; in_ready_o stays low until
// it ends.
// Stall: the result sits in an output register; the next request is still
// taken, and its walk holds at the end until the register frees up.
`default_nettype none
module sv39_page_table_mapper (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  sv39m_pkg::map_req_t       in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output sv39m_pkg::map_rsp_t       out_data_o,
  input  wire                       cfg_we_i,
  input  wire  [1:0]                cfg_idx_i,
  input  wire  [sv39m_pkg::PPN_W-1:0] cfg_data_i
);
  import sv39m_pkg::*;

  walk_state_e state_q, state_d;

  logic [ADDR_W-1:0]  clear_q, clear_d;
  logic [1:0]         level_q, level_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [VPN_W-1:0]   vpn_q, vpn_d;
  logic [PPN_W-1:0]   target_q, target_d;
  logic [1:0]         alloc_q, alloc_d;
  status_e            status_q, status_d;
  logic               was_valid_q, was_valid_d;
  logic [4:0]         nf_q, nf_d;
  logic [PPN_W-1:0]   base_q, base_d;
  logic [3:0]         root_q, root_d;
  map_rsp_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // table memory
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  logic               in_xfer;
  logic [IDX_W-1:0]   idx_sel;
  logic               pool_empty;
  logic               root_outside;
  logic [PPN_W-1:0]   ptr_off;
  logic               ptr_outside;
  logic               need_alloc;
  logic [PPN_W-1:0]   new_ppn;
  logic [CNT_W-1:0]   free_cnt;
  logic [4:0]         free_left;
  logic               out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (level_q)
      2'd2:    idx_sel = vpn_q[3*IDX_W-1:2*IDX_W];
      2'd1:    idx_sel = vpn_q[2*IDX_W-1:IDX_W];
      default: idx_sel = vpn_q[IDX_W-1:0];
    endcase
  end

  assign pool_empty = {{(CNT_W-5){1'b0}}, nf_q} >= CNT_W'(POOL_PAGES);
  assign root_outside = {{(CNT_W-4){1'b0}}, root_q} >= CNT_W'(POOL_PAGES);
  assign ptr_off = rdata_q[PPN_W+9:10] - base_q;
  assign ptr_outside = ptr_off >= PPN_W'(POOL_PAGES);
  assign need_alloc = !rdata_q[0];
  assign new_ppn = base_q + {{(PPN_W-5){1'b0}}, nf_q};
  assign free_cnt = CNT_W'(POOL_PAGES) - {{(CNT_W-5){1'b0}}, nf_q};

  always_comb begin
    if (pool_empty) begin
      free_left = 5'd0;
    end else if (free_cnt > CNT_W'(31)) begin
      free_left = 5'd31;
    end else begin
      free_left = free_cnt[4:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clear_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = root_outside ? S_FINISH : S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (level_q == 2'd0) begin
          state_d = S_FINISH;
        end else if (need_alloc) begin
          state_d = pool_empty ? S_FINISH : S_READ;
        end else begin
          state_d = ptr_outside ? S_FINISH : S_READ;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clear_d     = clear_q;
    level_d     = level_q;
    page_d      = page_q;
    vpn_d       = vpn_q;
    target_d    = target_q;
    alloc_d     = alloc_q;
    status_d    = status_q;
    was_valid_d = was_valid_q;
    nf_d        = nf_q;
    base_d      = base_q;
    root_d      = root_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_addr    = {page_q, idx_sel};
    mem_we      = 1'b0;
    mem_wdata   = {ENTRY_W{1'b0}};

    case (state_q)
      S_CLEAR: begin
        mem_addr = clear_q;
        mem_we   = 1'b1;
        clear_d  = clear_q + 1'b1;
      end
      S_IDLE: begin
        if (in_xfer) begin
          vpn_d       = in_data_i.virt_page;
          target_d    = in_data_i.phys_page;
          level_d     = 2'd2;
          page_d      = PAGE_W'(root_q);
          alloc_d     = 2'd0;
          was_valid_d = 1'b0;
          status_d    = root_outside ? ST_OUTSIDE : ST_MAPPED;
        end
      end
      S_EVAL: begin
        if (level_q == 2'd0) begin
          was_valid_d = rdata_q[0];
          mem_we      = 1'b1;
          mem_wdata   = {{(ENTRY_W-PPN_W-10){1'b0}}, target_q, FLAGS_LEAF};
        end else if (need_alloc) begin
          if (pool_empty) begin
            status_d = ST_EXHAUSTED;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {{(ENTRY_W-PPN_W-10){1'b0}}, new_ppn, FLAG_V};
            page_d    = PAGE_W'(nf_q);
            nf_d      = nf_q + 5'd1;
            alloc_d   = alloc_q + 2'd1;
            level_d   = level_q - 2'd1;
          end
        end else if (ptr_outside) begin
          status_d = ST_OUTSIDE;
        end else begin
          page_d  = PAGE_W'(ptr_off);
          level_d = level_q - 2'd1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.status          = status_q;
          out_d.pages_allocated = alloc_q;
          out_d.was_valid       = was_valid_q;
          out_d.free_pages_left = free_left;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE:  base_d = cfg_data_i;
        CFG_ROOT_PAGE:  root_d = cfg_data_i[3:0];
        CFG_FIRST_FREE: nf_d = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clear_q     <= {ADDR_W{1'b0}};
      nf_q        <= 5'd1;
      base_q      <= PPN_W'(524288);
      root_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clear_q     <= clear_d;
      nf_q        <= nf_d;
      base_q      <= base_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q     <= level_d;
    page_q      <= page_d;
    vpn_q       <= vpn_d;
    target_q    <= target_d;
    alloc_q     <= alloc_d;
    status_q    <= status_d;
    was_valid_q <= was_valid_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/tb_sv39_page_table_mapper.sv =====
module tb_sv39_page_table_mapper;
  import sv39m_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [PPN_W-1:0] BASE_AT_RESET = 44'd524288;
  localparam int ITEMS = 1800;
  localparam int CALM_FROM = 1550;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  map_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  map_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [PPN_W-1:0] cfg_data = '0;

  sv39_page_table_mapper uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the table pool, allocator and registers
  logic [ENTRY_W-1:0] shadow_table [DEPTH];
  logic [PPN_W-1:0]   shadow_base;
  logic [3:0]         shadow_root;
  int unsigned        shadow_next_free;

  map_req_t pending_maps [$];
  map_rsp_t awaited_status [$];
  int mismatches = 0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  logic [8:0] hot_l2 [4];
  logic [8:0] hot_l1 [4];
  logic [8:0] hot_l0 [4];

  function automatic map_rsp_t walk_table(map_req_t req);
    logic [8:0] lvl_idx [3];
    int unsigned page;
    int unsigned addr;
    logic [ENTRY_W-1:0] entry;
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] offs;
    status_e st;
    int unsigned taken;
    logic remap;
    int lvl;
    map_rsp_t rsp;
    lvl_idx[2] = req.virt_page[26:18];
    lvl_idx[1] = req.virt_page[17:9];
    lvl_idx[0] = req.virt_page[8:0];
    page = shadow_root;
    st = ST_MAPPED;
    taken = 0;
    remap = 1'b0;
    if (page >= POOL_PAGES) st = ST_OUTSIDE;
    for (lvl = 2; lvl >= 1; lvl--) begin
      if (st == ST_MAPPED) begin
        addr = page * ENTRIES_PER_PAGE + lvl_idx[lvl];
        entry = shadow_table[addr];
        if (!entry[0]) begin
          if (shadow_next_free >= POOL_PAGES) begin
            st = ST_EXHAUSTED;
          end else begin
            ppn = shadow_base + PPN_W'(shadow_next_free);
            shadow_next_free++;
            taken++;
            entry = {10'b0, ppn, FLAG_V};
            shadow_table[addr] = entry;
          end
        end
        // any valid entry is followed, leaf bits or not
        if (st == ST_MAPPED) begin
          offs = entry[PPN_W+9:10] - shadow_base;
          if (offs >= PPN_W'(POOL_PAGES)) st = ST_OUTSIDE;
          else page = int'(offs);
        end
      end
    end
    if (st == ST_MAPPED) begin
      addr = page * ENTRIES_PER_PAGE + lvl_idx[0];
      remap = shadow_table[addr][0];
      shadow_table[addr] = {10'b0, req.phys_page, FLAGS_LEAF};
    end
    rsp.status = st;
    rsp.pages_allocated = 2'(taken);
    rsp.was_valid = remap;
    rsp.free_pages_left = (shadow_next_free >= POOL_PAGES) ? 5'd0
                          : 5'(POOL_PAGES - shadow_next_free);
    return rsp;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [PPN_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_BASE: shadow_base = val;
      CFG_ROOT_PAGE: shadow_root = val[3:0];
      CFG_FIRST_FREE: shadow_next_free = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_maps.size() != 0 || in_valid || awaited_status.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic queue_map(input logic [VPN_W-1:0] vpn, input logic [PPN_W-1:0] ppn);
    map_req_t req;
    req.virt_page = vpn;
    req.phys_page = ppn;
    pending_maps.push_back(req);
  endtask

  function automatic logic [PPN_W-1:0] pick_phys();
    case ($urandom_range(0, 7))
      0: return shadow_base + PPN_W'($urandom_range(0, POOL_PAGES - 1));
      1: return '0;
      2: return '1;
      default: return PPN_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [VPN_W-1:0] pick_vpn();
    logic [8:0] i2;
    logic [8:0] i1;
    logic [8:0] i0;
    i2 = ($urandom_range(0, 3) == 0) ? 9'($urandom) : hot_l2[$urandom_range(0, 3)];
    i1 = ($urandom_range(0, 3) == 0) ? 9'($urandom) : hot_l1[$urandom_range(0, 3)];
    i0 = ($urandom_range(0, 1) == 0) ? 9'($urandom) : hot_l0[$urandom_range(0, 3)];
    return {i2, i1, i0};
  endfunction

  function automatic logic [PPN_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return '1 - PPN_W'($urandom_range(0, POOL_PAGES - 1));
      3: return PPN_W'({$urandom, $urandom});
      default: return BASE_AT_RESET;
    endcase
  endfunction

  function automatic logic [PPN_W-1:0] pick_first_free();
    case ($urandom_range(0, 7))
      0: return PPN_W'(POOL_PAGES);
      1: return PPN_W'($urandom_range(0, POOL_PAGES));
      default: return PPN_W'($urandom_range(0, 4));
    endcase
  endfunction

  // request side
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) awaited_status.push_back(walk_table(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_maps.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_maps.size() != 0) begin
          in_data <= pending_maps.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin : watch
    map_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_status.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status=%0d alloc=%0d remap=%0d free=%0d",
                     out_data.status, out_data.pages_allocated, out_data.was_valid,
                     out_data.free_pages_left);
          mismatches++;
        end else begin
          want = awaited_status.pop_front();
          if (out_data.status !== want.status
              || out_data.pages_allocated !== want.pages_allocated
              || out_data.was_valid !== want.was_valid
              || out_data.free_pages_left !== want.free_pages_left) begin
            if (mismatches < 10)
              $display("mismatch (status/alloc/remap/free): want %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       want.status, want.pages_allocated, want.was_valid,
                       want.free_pages_left, out_data.status, out_data.pages_allocated,
                       out_data.was_valid, out_data.free_pages_left);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #1000000;
    $display("** sv39_page_table_mapper: FAILED **");
    $finish;
  end

  initial begin
    int n_items;
    int phase_len;
    for (int i = 0; i < DEPTH; i++) shadow_table[i] = '0;
    shadow_base = BASE_AT_RESET;
    shadow_root = '0;
    shadow_next_free = 1;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    // fresh walks, a remap, an L1-only allocation, then run the pool dry
    queue_map('0, '0);
    queue_map('0, '1);
    queue_map('1, '1);
    queue_map({9'h1ff, 9'h000, 9'h000}, 44'h0_0000_0000_1);
    queue_map({9'h000, 9'h001, 9'h000}, BASE_AT_RESET + 44'd3);
    for (int i = 1; i <= 6; i++) queue_map({9'(i), 9'h0aa, 9'h155}, PPN_W'({$urandom, $urandom}));
    queue_map('0, 44'h5555_5555_555);  // existing path still maps with the pool empty
    wait_quiet();

    // stale pointers now fall outside the pool; unused index must be ignored
    write_reg(CFG_POOL_BASE, '0);
    write_reg(CFG_UNUSED, '1);
    queue_map('0, 44'h123);
    queue_map({9'h000, 9'h1ff, 9'h1ff}, 44'haaa_aaaa_aaaa);
    wait_quiet();

    // base at the top so page numbers wrap, root at the last page
    write_reg(CFG_POOL_BASE, '1 - 44'd2);
    write_reg(CFG_ROOT_PAGE, 44'd15);
    write_reg(CFG_FIRST_FREE, '0);
    queue_map({9'h0f0, 9'h00f, 9'h001}, 44'd1);
    queue_map({9'h0f0, 9'h00f, 9'h001}, 44'd2);
    queue_map({9'h0f0, 9'h1f0, 9'h100}, '1);
    queue_map({9'h033, 9'h0cc, 9'h0f0}, 44'd3);
    wait_quiet();

    // nothing left to allocate from the start
    write_reg(CFG_POOL_BASE, BASE_AT_RESET);
    write_reg(CFG_ROOT_PAGE, '0);
    write_reg(CFG_FIRST_FREE, PPN_W'(POOL_PAGES));
    queue_map({9'h17c, 9'h0c3, 9'h03c}, 44'h1);
    queue_map('0, 44'h2);
    queue_map({9'h1ff, 9'h000, 9'h1ff}, 44'h3);

    n_items = 0;
    while (n_items < ITEMS) begin
      wait_quiet();
      if (n_items >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) write_reg(CFG_POOL_BASE, pick_base());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_ROOT_PAGE, PPN_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FIRST_FREE, pick_first_free());
      if ($urandom_range(0, 15) == 0) write_reg(CFG_UNUSED, PPN_W'({$urandom, $urandom}));
      for (int i = 0; i < 4; i++) begin
        hot_l2[i] = ($urandom_range(0, 7) == 0) ? {9{i[0]}} : 9'($urandom);
        hot_l1[i] = ($urandom_range(0, 7) == 0) ? {9{i[0]}} : 9'($urandom);
        hot_l0[i] = 9'($urandom);
      end
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) queue_map(pick_vpn(), pick_phys());
      n_items += phase_len;
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("** sv39_page_table_mapper: PASSED **");
    end else begin
      $display("** sv39_page_table_mapper: FAILED **");
    end
    $finish;
  end

endmodule
